// File: src/rde_pkg.sv
`default_nettype none

package rde_pkg;

    localparam int OP_W     = 3;
    localparam int ELEM_W   = 16;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND  = 3'd1;
    localparam logic [OP_W-1:0] OP_REVERSE = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd3;
    localparam logic [OP_W-1:0] OP_TAKE    = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ERROR = 2'd2;

    typedef enum logic
    {
        ST_IDLE,
        ST_READ
    } state_t;

endpackage

`default_nettype wire

// File: src/rde_cmd_if.sv
`default_nettype none

interface rde_cmd_if;
    import rde_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ELEM_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

`default_nettype wire

// File: src/rde_rsp_if.sv
`default_nettype none

interface rde_rsp_if;
    import rde_pkg::*;

    logic                valid;
    logic                ready;
    logic [ELEM_W-1:0]   element;
    logic [STATUS_W-1:0] status;
    logic                last_one;

    modport source (output valid, output element, output status, output last_one,
                    input ready);
    modport sink   (input valid, input element, input status, input last_one,
                    output ready);
endinterface

`default_nettype wire

// File: src/reversible_deque_engine_core.sv
`default_nettype none

// Channel   Modport   Word
// cmd       sink      operation, value
// rsp       source    element, status, last_one
//
// Clear, append, reverse and delete update the state registers directly.
// A take that hands out an element first issues the store read; the registered
// read data then passes through the read state into the response register.
// Empty and error takes load the response register directly. No word is accepted in the read state.
// Reset is asynchronous and needs no clearing pass; unwritten entries are never read.
// A stalled response only holds back takes; other words are still accepted.

module reversible_deque_engine_core #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 16
) (
    input wire logic clk,
    input wire logic rst_n,
    rde_cmd_if.sink  cmd,
    rde_rsp_if.source rsp
);
    import rde_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t state_reg, state_next;

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic          reversed_reg, reversed_next;
    logic          error_reg, error_next;

    logic                out_valid_reg, out_valid_next;
    logic [ELEM_W-1:0]   out_element_reg, out_element_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                out_last_reg, out_last_next;

    logic            idle;
    logic            accept;
    logic            is_take;
    logic            is_full;
    logic            is_empty;
    logic            wr_en;
    logic            rd_en;
    logic [CW:0]     tail_sum;
    logic [CW:0]     back_sum;
    logic [AW-1:0]   tail_pos;
    logic [AW-1:0]   back_pos;
    logic [AW-1:0]   head_inc;
    logic [AW-1:0]   rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    // Pointer arithmetic: head + count stays below twice the depth.
    always_comb
    begin
        tail_sum = (CW+1)'(head_reg) + (CW+1)'(count_reg);
        back_sum = tail_sum - (CW+1)'(1);
        tail_pos = (tail_sum >= (CW+1)'(DEPTH)) ? AW'(tail_sum - (CW+1)'(DEPTH))
                                                 : AW'(tail_sum);
        back_pos = (back_sum >= (CW+1)'(DEPTH)) ? AW'(back_sum - (CW+1)'(DEPTH))
                                                 : AW'(back_sum);
        head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
        is_full  = (count_reg == CW'(DEPTH));
        is_empty = (count_reg == '0);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (rd_en)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        idle = 1'b0;
        case (state_reg)
            ST_IDLE: idle = 1'b1;
            ST_READ: idle = 1'b0;
            default: idle = 1'b0;
        endcase
    end

    // A take needs the response register free by the end of this cycle.
    always_comb
    begin
        is_take   = (cmd.operation == OP_TAKE);
        cmd.ready = idle && (!is_take || !out_valid_reg || rsp.ready);
        accept    = cmd.valid && cmd.ready;
        wr_en     = accept && (cmd.operation == OP_APPEND) && !error_reg && !is_full;
        rd_en     = accept && is_take && !error_reg && !is_empty;
        rd_addr   = reversed_reg ? back_pos : head_reg;
    end

    always_comb
    begin
        head_next        = head_reg;
        count_next       = count_reg;
        reversed_next    = reversed_reg;
        error_next       = error_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_element_next = out_element_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;

        if (state_reg == ST_READ)
        begin
            out_valid_next   = 1'b1;
            out_element_next = ELEM_W'(rd_data);
        end

        if (accept)
        begin
            case (cmd.operation)
                OP_CLEAR:
                begin
                    head_next     = '0;
                    count_next    = '0;
                    reversed_next = 1'b0;
                    error_next    = 1'b0;
                end
                OP_APPEND:
                begin
                    if (wr_en)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_REVERSE:
                begin
                    if (!error_reg)
                    begin
                        reversed_next = !reversed_reg;
                    end
                end
                OP_DELETE:
                begin
                    if (!error_reg)
                    begin
                        if (is_empty)
                        begin
                            error_next = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            if (!reversed_reg)
                            begin
                                head_next = head_inc;
                            end
                        end
                    end
                end
                OP_TAKE:
                begin
                    if (error_reg)
                    begin
                        out_valid_next   = 1'b1;
                        out_element_next = '0;
                        out_status_next  = STATUS_ERROR;
                        out_last_next    = 1'b1;
                    end
                    else if (is_empty)
                    begin
                        out_valid_next   = 1'b1;
                        out_element_next = '0;
                        out_status_next  = STATUS_EMPTY;
                        out_last_next    = 1'b1;
                    end
                    else
                    begin
                        // The element itself arrives from the store next cycle.
                        out_status_next = STATUS_OK;
                        out_last_next   = (count_reg == CW'(1));
                        count_next      = count_reg - CW'(1);
                        if (!reversed_reg)
                        begin
                            head_next = head_inc;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            reversed_reg  <= 1'b0;
            error_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            reversed_reg  <= reversed_next;
            error_reg     <= error_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_element_reg <= out_element_next;
        out_status_reg  <= out_status_next;
        out_last_reg    <= out_last_next;
    end

    rde_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_pos),
        .wr_data (DATA_WIDTH'(cmd.value)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rsp.valid    = out_valid_reg;
    assign rsp.element  = out_element_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.last_one = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
    else $error("element count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !out_valid_reg)
    else $error("store read returning while response register is occupied");

    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (state_reg == ST_READ) && !cmd.ready)
    else $error("take read not followed by read state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != STATUS_OK)) |-> out_last_reg)
    else $error("empty or error response without last flag");

endmodule

`default_nettype wire

// File: src/rde_ram.sv
`default_nettype none

module rde_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: verif/reversible_deque_engine_core_tb.sv
`default_nettype none

module reversible_deque_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rde_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int TARGET_CMDS = 1850;

    typedef struct packed
    {
        logic [OP_W-1:0]   op;
        logic [ELEM_W-1:0] value;
    } deque_cmd_t;

    typedef struct packed
    {
        logic [ELEM_W-1:0]   element;
        logic [STATUS_W-1:0] status;
        logic                last_one;
    } take_answer_t;

    logic clk;
    logic rst_n;

    rde_cmd_if cmd_if ();
    rde_rsp_if rsp_if ();

    reversible_deque_engine_core #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (ELEM_W)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if.sink),
        .rsp   (rsp_if.source)
    );

    // Shadow copy of the deque.
    logic [ELEM_W-1:0] shadow_mem [DEPTH];
    logic [9:0]        shadow_head;
    logic [10:0]       shadow_count;
    logic              shadow_flipped;
    logic              shadow_broken;

    deque_cmd_t   cmd_backlog[$];
    take_answer_t take_answers_due[$];

    int n_queued;
    int n_accepted;
    int n_given;
    int n_empty_takes;
    int n_error_takes;
    int n_dropped_full;
    int n_failures;

    int burst_left;
    int gap_left;
    int hold_left;
    bit hold_done;
    int seen_cmds;
    int rx_mode;
    int rx_mode_left;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Work out the effect of one accepted word on the shadow deque.
    function automatic void predict_deque_cmd(input logic [OP_W-1:0] op,
                                              input logic [ELEM_W-1:0] value);
        logic [9:0]   slot;
        take_answer_t ans;

        ans = '0;
        case (op)
            OP_CLEAR:
            begin
                shadow_head    = '0;
                shadow_count   = '0;
                shadow_flipped = 1'b0;
                shadow_broken  = 1'b0;
            end
            OP_APPEND:
            begin
                if (!shadow_broken && shadow_count >= DEPTH)
                    n_dropped_full++;
                if (!shadow_broken && shadow_count < DEPTH)
                begin
                    // Appends always land at the physical back.
                    slot = shadow_head + shadow_count[9:0];
                    shadow_mem[slot] = value;
                    shadow_count++;
                end
            end
            OP_REVERSE:
            begin
                if (!shadow_broken)
                    shadow_flipped = !shadow_flipped;
            end
            OP_DELETE:
            begin
                if (!shadow_broken)
                begin
                    if (shadow_count == 0)
                        shadow_broken = 1'b1;
                    else
                    begin
                        if (!shadow_flipped)
                            shadow_head++;
                        shadow_count--;
                    end
                end
            end
            OP_TAKE:
            begin
                if (shadow_broken)
                begin
                    ans.status   = STATUS_ERROR;
                    ans.last_one = 1'b1;
                    n_error_takes++;
                end
                else if (shadow_count == 0)
                begin
                    ans.status   = STATUS_EMPTY;
                    ans.last_one = 1'b1;
                    n_empty_takes++;
                end
                else
                begin
                    if (shadow_flipped)
                        slot = shadow_head + shadow_count[9:0] - 10'd1;
                    else
                    begin
                        slot = shadow_head;
                        shadow_head++;
                    end
                    shadow_count--;
                    ans.element  = shadow_mem[slot];
                    ans.status   = STATUS_OK;
                    ans.last_one = (shadow_count == 0);
                    n_given++;
                end
                take_answers_due = {take_answers_due, ans};
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [ELEM_W-1:0] value);
        deque_cmd_t c;

        c.op    = op;
        c.value = value;
        cmd_backlog = {cmd_backlog, c};
        if (op <= OP_TAKE)
            n_queued++;
    endtask

    function automatic logic [ELEM_W-1:0] pick_value();
        int r;

        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return ELEM_W'($urandom_range(0, 65535));
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        deque_cmd_t c;

        if (!rst_n)
        begin
            cmd_if.valid     <= 1'b0;
            cmd_if.operation <= OP_CLEAR;
            cmd_if.value     <= '0;
            burst_left       = 0;
            gap_left         = 0;
        end
        else
        begin
            if (cmd_if.valid && cmd_if.ready)
            begin
                predict_deque_cmd(cmd_if.operation, cmd_if.value);
                n_accepted++;
            end
            if (!cmd_if.valid || cmd_if.ready)
            begin
                if (gap_left != 0 || cmd_backlog.size() == 0)
                begin
                    if (gap_left != 0)
                        gap_left--;
                    cmd_if.valid <= 1'b0;
                end
                else
                begin
                    c = cmd_backlog[0];
                    cmd_backlog.delete(0);
                    cmd_if.valid     <= 1'b1;
                    cmd_if.operation <= c.op;
                    cmd_if.value     <= c.value;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
            end
        end
    end

    // Receiver: stall pattern of its own, plus one long hold-off so that
    // pending takes back up and the block stops accepting words.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            hold_left    = 0;
            hold_done    = 1'b0;
            seen_cmds    = 0;
            rx_mode      = 0;
            rx_mode_left = 0;
        end
        else
        begin
            if (cmd_if.valid && cmd_if.ready)
                seen_cmds++;
            if (!hold_done && seen_cmds >= 300)
            begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (rx_mode_left == 0)
            begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(32, 200);
            end
            else
                rx_mode_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       rsp_if.ready <= 1'b1;
                    1:       rsp_if.ready <= $urandom_range(0, 1);
                    2:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
                    default: rsp_if.ready <= ((rx_mode_left % 3) == 0);
                endcase
            end
        end
    end

    // Compare every accepted response word with the oldest expected answer.
    always @(posedge clk)
    begin
        take_answer_t want;

        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (take_answers_due.size() == 0)
            begin
                $error("unexpected response word: element %0h status %0d last_one %0b",
                       rsp_if.element, rsp_if.status, rsp_if.last_one);
                n_failures++;
            end
            else
            begin
                want = take_answers_due[0];
                take_answers_due.delete(0);
                if (rsp_if.element !== want.element)
                begin
                    $error("element: expected %0h, got %0h", want.element, rsp_if.element);
                    n_failures++;
                end
                if (rsp_if.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                    n_failures++;
                end
                if (rsp_if.last_one !== want.last_one)
                begin
                    $error("last_one: expected %0b, got %0b", want.last_one, rsp_if.last_one);
                    n_failures++;
                end
            end
        end
    end

    initial
    begin
        int  r;
        int  len;
        bit  filled;

        // Applied late in the first time step so that the clocked processes see the edge.
        rst_n <= 1'b0;
        n_queued       = 0;
        n_accepted     = 0;
        n_given        = 0;
        n_empty_takes  = 0;
        n_error_takes  = 0;
        n_dropped_full = 0;
        n_failures     = 0;
        shadow_head    = '0;
        shadow_count   = '0;
        shadow_flipped = 1'b0;
        shadow_broken  = 1'b0;
        filled         = 1'b0;

        // Directed opening: empty take, extreme values, reversed reads,
        // append while reversed, the sticky error and unknown codes.
        queue_cmd(OP_CLEAR, '0);
        queue_cmd(OP_TAKE, '0);
        queue_cmd(OP_APPEND, 16'h0000);
        queue_cmd(OP_APPEND, 16'hFFFF);
        queue_cmd(OP_APPEND, 16'h5A5A);
        queue_cmd(OP_TAKE, '0);
        queue_cmd(OP_REVERSE, '0);
        queue_cmd(OP_TAKE, '0);
        queue_cmd(OP_APPEND, 16'h0001);
        queue_cmd(OP_TAKE, '0);
        queue_cmd(OP_TAKE, '0);
        queue_cmd(OP_TAKE, '0);
        queue_cmd(OP_DELETE, '0);
        queue_cmd(OP_APPEND, 16'h0007);
        queue_cmd(OP_REVERSE, '0);
        queue_cmd(OP_DELETE, '0);
        queue_cmd(OP_TAKE, '0);
        queue_cmd(3'd5, 16'hAAAA);
        queue_cmd(3'd6, 16'h5555);
        queue_cmd(3'd7, 16'hFFFF);
        queue_cmd(OP_CLEAR, '0);
        queue_cmd(OP_APPEND, 16'h0003);
        queue_cmd(OP_APPEND, 16'h0004);
        queue_cmd(OP_DELETE, '0);
        queue_cmd(OP_TAKE, '0);

        while (n_queued < TARGET_CMDS)
        begin
            if (!filled && n_queued >= 500)
            begin
                // Fill to the brim, overflow, then wrap the back round the ring.
                filled = 1'b1;
                queue_cmd(OP_CLEAR, '0);
                for (int i = 0; i < DEPTH + 2; i++)
                    queue_cmd(OP_APPEND, pick_value());
                for (int i = 0; i < 12; i++)
                    queue_cmd(OP_TAKE, '0);
                for (int i = 0; i < 14; i++)
                    queue_cmd(OP_APPEND, pick_value());
                queue_cmd(OP_REVERSE, '0);
                for (int i = 0; i < 6; i++)
                    queue_cmd(OP_TAKE, '0);
                for (int i = 0; i < 3; i++)
                    queue_cmd(OP_DELETE, '0);
                queue_cmd(OP_REVERSE, '0);
                for (int i = 0; i < 4; i++)
                    queue_cmd(OP_TAKE, '0);
                queue_cmd(OP_CLEAR, '0);
            end
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                len = $urandom_range(1, 12);
                repeat (len) queue_cmd(OP_APPEND, pick_value());
            end
            else if (r < 55)
            begin
                len = $urandom_range(1, 8);
                repeat (len) queue_cmd(OP_TAKE, '0);
            end
            else if (r < 65)
                queue_cmd(OP_REVERSE, '0);
            else if (r < 73)
            begin
                len = $urandom_range(1, 3);
                repeat (len) queue_cmd(OP_DELETE, '0);
            end
            else if (r < 78)
                queue_cmd(OP_CLEAR, '0);
            else if (r < 82)
                queue_cmd(OP_W'($urandom_range(5, 7)), pick_value());
            else if (r < 86)
            begin
                // Break the deque, poke at it, then recover.
                queue_cmd(OP_CLEAR, '0);
                queue_cmd(OP_DELETE, '0);
                queue_cmd(OP_APPEND, pick_value());
                queue_cmd(OP_REVERSE, '0);
                queue_cmd(OP_DELETE, '0);
                queue_cmd(OP_TAKE, '0);
                queue_cmd(OP_TAKE, '0);
                queue_cmd(OP_CLEAR, '0);
            end
            else
            begin
                len = $urandom_range(1, 10);
                repeat (len) queue_cmd(OP_W'($urandom_range(1, 4)), pick_value());
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || cmd_if.valid)
            @(posedge clk);
        while (take_answers_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Run covered %0d commands, including a full deque with %0d dropped appends.",
                 n_accepted, n_dropped_full);
        $display("Takes: %0d elements handed out, %0d on an empty deque, %0d in error.",
                 n_given, n_empty_takes, n_error_takes);
        if (n_failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
src/rde_pkg.sv
src/rde_cmd_if.sv
src/rde_rsp_if.sv
src/rde_ram.sv
src/reversible_deque_engine_core.sv
verif/reversible_deque_engine_core_tb.sv
